@@ rtl/tfst_pkg.sv @@
`default_nettype none
package tfst_pkg;

    localparam int FLOW_ENTRIES = 16384;
    localparam int IDX_W = $clog2(FLOW_ENTRIES);
    localparam int CNT_W = IDX_W + 1;
    localparam int HEAD_DEPTH = 2 ** IDX_W;
    localparam int KEY_W = 96;
    localparam int KRAM_W = 1 + IDX_W + KEY_W;
    localparam int HRAM_W = 1 + IDX_W;
    localparam int FRAM_W = 6;
    localparam int DRAM_W = 112;

    localparam logic [31:0] PKT_MAX = 32'hFFFF_FFFF;
    localparam logic [47:0] BYTE_MAX = 48'hFFFF_FFFF_FFFF;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [2:0] cstate_t;

    localparam cstate_t CS_CLOSED = 3'd0;
    localparam cstate_t CS_SYN_SENT = 3'd1;
    localparam cstate_t CS_SYN_RCVD = 3'd2;
    localparam cstate_t CS_ESTAB = 3'd3;
    localparam cstate_t CS_FIN_WAIT = 3'd4;

    localparam logic [1:0] LS_NONE = 2'd0;
    localparam logic [1:0] LS_EXISTING = 2'd1;
    localparam logic [1:0] LS_CREATED = 2'd2;

    typedef struct packed {
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq;
        logic        syn;
        logic        ack;
        logic        fin;
        logic        rst;
        logic [15:0] len;
        idx_t        hf;
        idx_t        hr;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] index;
        logic        dir;
        cstate_t     cstate;
        logic [31:0] dir_seq;
        logic [31:0] packets;
        logic [47:0] bytes;
        logic [2:0]  seen;
    } res_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FHEAD,
        ST_FCMP,
        ST_RHEAD,
        ST_RCMP,
        ST_CREATE,
        ST_CREATE2,
        ST_MODIFY
    } fsm_t;

    function automatic idx_t flow_hash(input logic [KEY_W-1:0] k);
        idx_t h;
        h = '0;
        for (int i = 0; i < KEY_W; i++)
        begin
            h[i % IDX_W] = h[i % IDX_W] ^ k[i];
        end
        return h;
    endfunction

endpackage
`default_nettype wire

@@ rtl/tfst_ram.sv @@
`default_nettype none
module tfst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/tfst_front.sv @@
`default_nettype none
module tfst_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] source_address,
    input  wire logic [31:0] dest_address,
    input  wire logic [15:0] source_port,
    input  wire logic [15:0] dest_port,
    input  wire logic [31:0] sequence_number,
    input  wire logic        flag_syn,
    input  wire logic        flag_ack,
    input  wire logic        flag_fin,
    input  wire logic        flag_rst,
    input  wire logic [15:0] packet_length,
    output logic             q_valid,
    output tfst_pkg::item_t  q_item,
    input  wire logic        q_pop
);
    tfst_pkg::item_t slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic wp_reg, rp_reg;
    logic push_ok;
    tfst_pkg::item_t in_item;

    // classify: both bucket hashes computed on the way in
    always_comb
    begin
        in_item.saddr = source_address;
        in_item.daddr = dest_address;
        in_item.sport = source_port;
        in_item.dport = dest_port;
        in_item.seq = sequence_number;
        in_item.syn = flag_syn;
        in_item.ack = flag_ack;
        in_item.fin = flag_fin;
        in_item.rst = flag_rst;
        in_item.len = packet_length;
        in_item.hf = tfst_pkg::flow_hash({source_address, dest_address, source_port, dest_port});
        in_item.hr = tfst_pkg::flow_hash({dest_address, source_address, dest_port, source_port});
    end

    assign full = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = slot_reg[rp_reg];
    assign push_ok = push && !full;
    assign cnt_next = cnt_reg + {1'b0, push_ok} - {1'b0, q_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push_ok)
            begin
                wp_reg <= !wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slot_reg[wp_reg] <= in_item;
        end
    end
endmodule
`default_nettype wire

@@ rtl/tfst_back.sv @@
`default_nettype none
module tfst_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire tfst_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 res_valid,
    output tfst_pkg::res_t       res,
    input  wire logic            res_pop
);
    localparam int IW = tfst_pkg::IDX_W;
    localparam int CW = tfst_pkg::CNT_W;
    localparam int KW = tfst_pkg::KEY_W;

    tfst_pkg::fsm_t state_reg, state_next;
    tfst_pkg::item_t item_reg, item_next;
    tfst_pkg::idx_t cur_reg, cur_next, idx_reg, idx_next, clr_reg, clr_next;
    logic [tfst_pkg::HRAM_W-1:0] fhead_reg, fhead_next;
    logic rev_reg, rev_next;
    logic [CW-1:0] count_reg, count_next;
    logic ov_reg, ov_next;
    tfst_pkg::res_t res_reg, res_next;

    logic h_we, h_re, k_we, k_re, f_we, f_re, d_we, d_re;
    tfst_pkg::idx_t h_waddr, h_raddr, k_waddr, k_raddr, f_waddr, f_raddr;
    logic [CW-1:0] d_waddr, d_raddr;
    logic [tfst_pkg::HRAM_W-1:0] h_wdata, h_rdata;
    logic [tfst_pkg::KRAM_W-1:0] k_wdata, k_rdata;
    logic [tfst_pkg::FRAM_W-1:0] f_wdata, f_rdata;
    logic [tfst_pkg::DRAM_W-1:0] d_wdata, d_rdata;

    logic [KW-1:0] fkey, rkey;
    logic head_hit, next_hit, fmatch, rmatch, kd_rev, create_ok;
    tfst_pkg::idx_t head_ptr, next_ptr;
    tfst_pkg::cstate_t m_st, c_st;
    logic [2:0] m_seen, c_seen;
    logic [31:0] m_ns, m_pk;
    logic [47:0] m_by;
    logic [48:0] m_sum;

    tfst_ram #(.WIDTH(tfst_pkg::HRAM_W), .DEPTH(tfst_pkg::HEAD_DEPTH)) u_head (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .re(h_re), .raddr(h_raddr), .rdata(h_rdata));
    tfst_ram #(.WIDTH(tfst_pkg::KRAM_W), .DEPTH(tfst_pkg::FLOW_ENTRIES)) u_key (
        .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .re(k_re), .raddr(k_raddr), .rdata(k_rdata));
    tfst_ram #(.WIDTH(tfst_pkg::FRAM_W), .DEPTH(tfst_pkg::FLOW_ENTRIES)) u_flow (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .re(f_re), .raddr(f_raddr), .rdata(f_rdata));
    tfst_ram #(.WIDTH(tfst_pkg::DRAM_W), .DEPTH(2 * tfst_pkg::FLOW_ENTRIES)) u_dir (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .re(d_re), .raddr(d_raddr), .rdata(d_rdata));

    assign fkey = {item_reg.saddr, item_reg.daddr, item_reg.sport, item_reg.dport};
    assign rkey = {item_reg.daddr, item_reg.saddr, item_reg.dport, item_reg.sport};
    assign head_hit = h_rdata[IW];
    assign head_ptr = h_rdata[IW-1:0];
    assign next_hit = k_rdata[tfst_pkg::KRAM_W-1];
    assign next_ptr = k_rdata[KW +: IW];
    assign fmatch = (k_rdata[KW-1:0] == fkey);
    assign rmatch = (k_rdata[KW-1:0] == rkey);
    // originator is the stored source address and source port
    assign kd_rev = !((k_rdata[95:64] == item_reg.saddr) && (k_rdata[31:16] == item_reg.sport));
    assign create_ok = item_reg.syn && (count_reg != CW'(tfst_pkg::FLOW_ENTRIES));
    assign q_pop = (state_reg == tfst_pkg::ST_IDLE) && q_valid && !ov_reg;
    assign res_valid = ov_reg;
    assign res = res_reg;

    // update of an existing flow
    always_comb
    begin
        m_st = f_rdata[5:3];
        m_seen = f_rdata[2:0];
        m_ns = d_rdata[111:80];
        m_pk = d_rdata[79:48];
        m_by = d_rdata[47:0];
        if (item_reg.syn)
        begin
            m_seen = m_seen | 3'b001;
            m_ns = item_reg.seq + 32'd1;
            if (!rev_reg)
            begin
                m_st = tfst_pkg::CS_SYN_SENT;
            end
            else if (item_reg.ack)
            begin
                m_st = tfst_pkg::CS_SYN_RCVD;
            end
        end
        if (item_reg.ack && m_st == tfst_pkg::CS_SYN_RCVD)
        begin
            m_st = tfst_pkg::CS_ESTAB;
        end
        if (item_reg.fin)
        begin
            m_seen = m_seen | 3'b010;
            if (m_st == tfst_pkg::CS_ESTAB)
            begin
                m_st = tfst_pkg::CS_FIN_WAIT;
            end
        end
        if (item_reg.rst)
        begin
            m_seen = m_seen | 3'b100;
            m_st = tfst_pkg::CS_CLOSED;
        end
        if (m_pk != tfst_pkg::PKT_MAX)
        begin
            m_pk = m_pk + 32'd1;
        end
        m_sum = {1'b0, m_by} + {33'd0, item_reg.len};
        m_by = m_sum[48] ? tfst_pkg::BYTE_MAX : m_sum[47:0];
    end

    // first packet of a new flow, applied as forward
    always_comb
    begin
        c_st = item_reg.rst ? tfst_pkg::CS_CLOSED : tfst_pkg::CS_SYN_SENT;
        c_seen = {item_reg.rst, item_reg.fin, 1'b1};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tfst_pkg::ST_CLEAR:
            begin
                if (clr_reg == IW'(tfst_pkg::HEAD_DEPTH - 1))
                begin
                    state_next = tfst_pkg::ST_IDLE;
                end
            end
            tfst_pkg::ST_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    state_next = tfst_pkg::ST_FHEAD;
                end
            end
            tfst_pkg::ST_FHEAD:
            begin
                state_next = head_hit ? tfst_pkg::ST_FCMP : tfst_pkg::ST_RHEAD;
            end
            tfst_pkg::ST_FCMP:
            begin
                if (fmatch)
                begin
                    state_next = tfst_pkg::ST_MODIFY;
                end
                else if (!next_hit)
                begin
                    state_next = tfst_pkg::ST_RHEAD;
                end
            end
            tfst_pkg::ST_RHEAD:
            begin
                if (head_hit)
                begin
                    state_next = tfst_pkg::ST_RCMP;
                end
                else
                begin
                    state_next = create_ok ? tfst_pkg::ST_CREATE : tfst_pkg::ST_IDLE;
                end
            end
            tfst_pkg::ST_RCMP:
            begin
                if (rmatch)
                begin
                    state_next = tfst_pkg::ST_MODIFY;
                end
                else if (!next_hit)
                begin
                    state_next = create_ok ? tfst_pkg::ST_CREATE : tfst_pkg::ST_IDLE;
                end
            end
            tfst_pkg::ST_CREATE:  state_next = tfst_pkg::ST_CREATE2;
            tfst_pkg::ST_CREATE2: state_next = tfst_pkg::ST_IDLE;
            tfst_pkg::ST_MODIFY:  state_next = tfst_pkg::ST_IDLE;
            default:              state_next = tfst_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_next = item_reg;
        cur_next = cur_reg;
        idx_next = idx_reg;
        clr_next = clr_reg;
        fhead_next = fhead_reg;
        rev_next = rev_reg;
        count_next = count_reg;
        ov_next = ov_reg && !res_pop;
        res_next = res_reg;
        h_we = 1'b0;
        h_waddr = clr_reg;
        h_wdata = '0;
        h_re = 1'b0;
        h_raddr = item_reg.hr;
        k_we = 1'b0;
        k_waddr = count_reg[IW-1:0];
        k_wdata = {fhead_reg, fkey};
        k_re = 1'b0;
        k_raddr = next_ptr;
        f_we = 1'b0;
        f_waddr = idx_reg;
        f_wdata = {m_st, m_seen};
        f_re = 1'b0;
        f_raddr = cur_reg;
        d_we = 1'b0;
        d_waddr = {idx_reg, rev_reg};
        d_wdata = {m_ns, m_pk, m_by};
        d_re = 1'b0;
        d_raddr = {cur_reg, kd_rev};
        case (state_reg)
            tfst_pkg::ST_CLEAR:
            begin
                h_we = 1'b1;
                clr_next = clr_reg + IW'(1);
            end
            tfst_pkg::ST_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    item_next = q_item;
                    h_re = 1'b1;
                    h_raddr = q_item.hf;
                end
            end
            tfst_pkg::ST_FHEAD, tfst_pkg::ST_RHEAD:
            begin
                if (state_reg == tfst_pkg::ST_FHEAD)
                begin
                    fhead_next = h_rdata;
                end
                if (head_hit)
                begin
                    k_re = 1'b1;
                    k_raddr = head_ptr;
                    cur_next = head_ptr;
                end
                else if (state_reg == tfst_pkg::ST_FHEAD)
                begin
                    h_re = 1'b1;
                end
                else if (!create_ok)
                begin
                    ov_next = 1'b1;
                    res_next = '0;
                end
            end
            tfst_pkg::ST_FCMP, tfst_pkg::ST_RCMP:
            begin
                if ((state_reg == tfst_pkg::ST_FCMP) ? fmatch : rmatch)
                begin
                    idx_next = cur_reg;
                    rev_next = kd_rev;
                    f_re = 1'b1;
                    d_re = 1'b1;
                end
                else if (next_hit)
                begin
                    k_re = 1'b1;
                    cur_next = next_ptr;
                end
                else if (state_reg == tfst_pkg::ST_FCMP)
                begin
                    h_re = 1'b1;
                end
                else if (!create_ok)
                begin
                    ov_next = 1'b1;
                    res_next = '0;
                end
            end
            tfst_pkg::ST_CREATE:
            begin
                idx_next = count_reg[IW-1:0];
                count_next = count_reg + CW'(1);
                k_we = 1'b1;
                h_we = 1'b1;
                h_waddr = item_reg.hf;
                h_wdata = {1'b1, count_reg[IW-1:0]};
                f_we = 1'b1;
                f_waddr = count_reg[IW-1:0];
                f_wdata = {c_st, c_seen};
                d_we = 1'b1;
                d_waddr = {count_reg[IW-1:0], 1'b0};
                d_wdata = {item_reg.seq + 32'd1, 32'd1, 32'd0, item_reg.len};
                ov_next = 1'b1;
                res_next.status = tfst_pkg::LS_CREATED;
                res_next.index = 14'(count_reg[IW-1:0]);
                res_next.dir = 1'b0;
                res_next.cstate = c_st;
                res_next.dir_seq = item_reg.seq + 32'd1;
                res_next.packets = 32'd1;
                res_next.bytes = {32'd0, item_reg.len};
                res_next.seen = c_seen;
            end
            tfst_pkg::ST_CREATE2:
            begin
                // reverse slot of the new flow starts at zero
                d_we = 1'b1;
                d_waddr = {idx_reg, 1'b1};
                d_wdata = '0;
            end
            tfst_pkg::ST_MODIFY:
            begin
                f_we = 1'b1;
                d_we = 1'b1;
                ov_next = 1'b1;
                res_next.status = tfst_pkg::LS_EXISTING;
                res_next.index = 14'(idx_reg);
                res_next.dir = rev_reg;
                res_next.cstate = m_st;
                res_next.dir_seq = m_ns;
                res_next.packets = m_pk;
                res_next.bytes = m_by;
                res_next.seen = m_seen;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tfst_pkg::ST_CLEAR;
            clr_reg <= '0;
            count_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            count_reg <= count_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        fhead_reg <= fhead_next;
        rev_reg <= rev_next;
        res_reg <= res_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(tfst_pkg::FLOW_ENTRIES))
        else $error("flow count beyond table size");
    a_modify_after_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tfst_pkg::ST_MODIFY |->
        ($past(state_reg) == tfst_pkg::ST_FCMP || $past(state_reg) == tfst_pkg::ST_RCMP))
        else $error("update without a key match");
    a_create_pair: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tfst_pkg::ST_CREATE |=> state_reg == tfst_pkg::ST_CREATE2)
        else $error("create did not clear reverse slot");
    a_take_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == tfst_pkg::ST_FHEAD && !ov_reg)
        else $error("item taken while result pending");
endmodule
`default_nettype wire

@@ rtl/tcp_flow_state_tracker.sv @@
// result path: the back end reads the forward bucket head and walks its chain, then the
//   reverse bucket and its chain if there is no match; a match updates the flow, a syn
//   with no match creates one while the table has room, and any other header is ignored;
//   the back end starts the next header only after the previous result transfer
// reset: asynchronous, active low; afterwards the bucket head memory is swept over all
//   HEAD_DEPTH entries (16384) while pushes queue up but no header is processed
`default_nettype none
module tcp_flow_state_tracker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] source_address,
    input  wire logic [31:0] dest_address,
    input  wire logic [15:0] source_port,
    input  wire logic [15:0] dest_port,
    input  wire logic [31:0] sequence_number,
    input  wire logic        flag_syn,
    input  wire logic        flag_ack,
    input  wire logic        flag_fin,
    input  wire logic        flag_rst,
    input  wire logic [15:0] packet_length,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       lookup_status,
    output logic [13:0]      flow_index,
    output logic             direction,
    output logic [2:0]       conn_state,
    output logic [31:0]      dir_next_sequence,
    output logic [31:0]      dir_packet_count,
    output logic [47:0]      dir_byte_count,
    output logic [2:0]       seen_flags
);
    // front end: takes a header transfer, hashes forward and reversed keys,
    // and holds up to two headers for the back end
    logic            q_valid;
    logic            q_pop;
    tfst_pkg::item_t q_item;

    // back end: chained hash table, flows numbered in creation order,
    // each entry links to the previous head of its bucket
    logic            res_valid;
    logic            res_pop;
    tfst_pkg::res_t  res;

    tfst_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .source_address(source_address),
        .dest_address(dest_address),
        .source_port(source_port),
        .dest_port(dest_port),
        .sequence_number(sequence_number),
        .flag_syn(flag_syn),
        .flag_ack(flag_ack),
        .flag_fin(flag_fin),
        .flag_rst(flag_rst),
        .packet_length(packet_length),
        .q_valid(q_valid),
        .q_item(q_item),
        .q_pop(q_pop)
    );

    tfst_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_valid(q_valid),
        .q_item(q_item),
        .q_pop(q_pop),
        .res_valid(res_valid),
        .res(res),
        .res_pop(res_pop)
    );

    // result register lives in the back end; a result transfer frees it
    assign empty = !res_valid;
    assign res_pop = pop && res_valid;

    assign lookup_status = res.status;
    assign flow_index = res.index;
    assign direction = res.dir;
    assign conn_state = res.cstate;
    assign dir_next_sequence = res.dir_seq;
    assign dir_packet_count = res.packets;
    assign dir_byte_count = res.bytes;
    assign seen_flags = res.seen;
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;

    // one tcp header as the sender sees it
    typedef struct {
        logic [31:0] sa;
        logic [31:0] da;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [31:0] seq;
        logic        syn;
        logic        ack;
        logic        fin;
        logic        rst;
        logic [15:0] len;
    } hdr_t;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int POOL_SIZE = 24;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full;
    logic empty;
    logic [31:0] source_address = '0;
    logic [31:0] dest_address = '0;
    logic [15:0] source_port = '0;
    logic [15:0] dest_port = '0;
    logic [31:0] sequence_number = '0;
    logic flag_syn = 1'b0;
    logic flag_ack = 1'b0;
    logic flag_fin = 1'b0;
    logic flag_rst = 1'b0;
    logic [15:0] packet_length = '0;
    logic [1:0] lookup_status;
    logic [13:0] flow_index;
    logic direction;
    logic [2:0] conn_state;
    logic [31:0] dir_next_sequence;
    logic [31:0] dir_packet_count;
    logic [47:0] dir_byte_count;
    logic [2:0] seen_flags;

    tcp_flow_state_tracker i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .source_address    (source_address),
        .dest_address      (dest_address),
        .source_port       (source_port),
        .dest_port         (dest_port),
        .sequence_number   (sequence_number),
        .flag_syn          (flag_syn),
        .flag_ack          (flag_ack),
        .flag_fin          (flag_fin),
        .flag_rst          (flag_rst),
        .packet_length     (packet_length),
        .empty             (empty),
        .pop               (pop),
        .lookup_status     (lookup_status),
        .flow_index        (flow_index),
        .direction         (direction),
        .conn_state        (conn_state),
        .dir_next_sequence (dir_next_sequence),
        .dir_packet_count  (dir_packet_count),
        .dir_byte_count    (dir_byte_count),
        .seen_flags        (seen_flags)
    );

    always #5 clk = ~clk;

    // headers waiting to be sent, indexed by transfer number
    hdr_t hdr_q[$];
    // results the flow table should produce, oldest first
    tfst_pkg::res_t flow_result_q[$];

    int sent_cnt = 0;
    int shown_idx = -1;
    int got_cnt = 0;
    int err_cnt = 0;
    int idle_cycles = 0;
    int created_cnt = 0;
    int missed_cnt = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // shadow flow table: tuple to entry number, plus per-entry and per-slot state
    int flow_of[bit [95:0]];
    int flows_in_use = 0;
    logic [31:0] orig_sa[int];
    logic [15:0] orig_sp[int];
    tfst_pkg::cstate_t fstate[int];
    logic [2:0] fseen[int];
    logic [31:0] nseq[int];
    logic [31:0] npkts[int];
    logic [47:0] nbytes[int];

    // connection pool used by the random traffic, with a per-connection step counter
    logic [31:0] pool_sa[POOL_SIZE];
    logic [31:0] pool_da[POOL_SIZE];
    logic [15:0] pool_sp[POOL_SIZE];
    logic [15:0] pool_dp[POOL_SIZE];
    int pool_step[POOL_SIZE];

    function automatic tfst_pkg::res_t track_packet(hdr_t p);
        bit [95:0] fk;
        bit [95:0] rk;
        int f;
        int s;
        logic rev;
        tfst_pkg::cstate_t st;
        tfst_pkg::res_t r;
        fk = {p.sa, p.da, p.sp, p.dp};
        rk = {p.da, p.sa, p.dp, p.sp};
        r = '0;
        r.status = tfst_pkg::LS_EXISTING;
        if (flow_of.exists(fk))
        begin
            f = flow_of[fk];
        end
        else if (flow_of.exists(rk))
        begin
            f = flow_of[rk];
        end
        else
        begin
            // no flow: ignored unless a syn opens one in the next free entry
            if (!p.syn || flows_in_use >= tfst_pkg::FLOW_ENTRIES)
            begin
                r = '0;
                return r;
            end
            f = flows_in_use;
            flows_in_use++;
            flow_of[fk] = f;
            orig_sa[f] = p.sa;
            orig_sp[f] = p.sp;
            fstate[f] = tfst_pkg::CS_SYN_SENT;
            fseen[f] = 3'b001;
            nseq[2*f] = p.seq + 32'd1;
            nseq[2*f+1] = '0;
            npkts[2*f] = '0;
            npkts[2*f+1] = '0;
            nbytes[2*f] = '0;
            nbytes[2*f+1] = '0;
            r.status = tfst_pkg::LS_CREATED;
        end
        // direction is relative to whoever opened the flow
        rev = (orig_sa[f] == p.sa && orig_sp[f] == p.sp) ? 1'b0 : 1'b1;
        s = 2 * f + int'(rev);
        st = fstate[f];
        if (p.syn)
        begin
            fseen[f][0] = 1'b1;
            nseq[s] = p.seq + 32'd1;
            if (!rev)
                st = tfst_pkg::CS_SYN_SENT;
            else if (p.ack)
                st = tfst_pkg::CS_SYN_RCVD;
        end
        if (p.ack && st == tfst_pkg::CS_SYN_RCVD)
            st = tfst_pkg::CS_ESTAB;
        if (p.fin)
        begin
            fseen[f][1] = 1'b1;
            if (st == tfst_pkg::CS_ESTAB)
                st = tfst_pkg::CS_FIN_WAIT;
        end
        if (p.rst)
        begin
            fseen[f][2] = 1'b1;
            st = tfst_pkg::CS_CLOSED;
        end
        fstate[f] = st;
        if (npkts[s] != tfst_pkg::PKT_MAX)
            npkts[s] = npkts[s] + 32'd1;
        if (tfst_pkg::BYTE_MAX - nbytes[s] < {32'd0, p.len})
            nbytes[s] = tfst_pkg::BYTE_MAX;
        else
            nbytes[s] = nbytes[s] + {32'd0, p.len};
        r.index = f[13:0];
        r.dir = rev;
        r.cstate = st;
        r.dir_seq = nseq[s];
        r.packets = npkts[s];
        r.bytes = nbytes[s];
        r.seen = fseen[f];
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    function automatic hdr_t make_hdr(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                                      logic [15:0] dp, logic [3:0] flags, logic [31:0] seq,
                                      logic [15:0] len);
        hdr_t h;
        h.sa = sa;
        h.da = da;
        h.sp = sp;
        h.dp = dp;
        h.seq = seq;
        {h.syn, h.ack, h.fin, h.rst} = flags;
        h.len = len;
        return h;
    endfunction

    function automatic logic [15:0] rand_len();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 16'd0;
        if (pick == 1)
            return 16'hFFFF;
        return 16'($urandom_range(40, 1500));
    endfunction

    function automatic void refresh_conn(int c);
        pool_sa[c] = $urandom;
        pool_da[c] = $urandom;
        pool_sp[c] = 16'($urandom);
        pool_dp[c] = 16'($urandom);
        pool_step[c] = 0;
    endfunction

    // mostly handshake-shaped traffic on known connections, some noise and broken flag sets
    function automatic hdr_t rand_hdr();
        int c;
        int pick;
        logic rev;
        logic [3:0] flags;
        hdr_t h;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            h = make_hdr($urandom, $urandom, 16'($urandom), 16'($urandom), 4'($urandom),
                         $urandom, rand_len());
            return h;
        end
        c = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 29) == 0)
            refresh_conn(c);
        case (pool_step[c])
            0: begin rev = 1'b0; flags = 4'b1000; end
            1: begin rev = 1'b1; flags = 4'b1100; end
            2: begin rev = 1'b0; flags = 4'b0100; end
            default:
            begin
                rev = 1'($urandom_range(0, 1));
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    flags = 4'b0110;
                else if (pick < 10)
                    flags = 4'b0001;
                else if (pick < 20)
                    flags = 4'($urandom);
                else
                    flags = 4'b0100;
            end
        endcase
        pool_step[c]++;
        if (!rev)
            h = make_hdr(pool_sa[c], pool_da[c], pool_sp[c], pool_dp[c], flags, $urandom,
                         rand_len());
        else
            h = make_hdr(pool_da[c], pool_sa[c], pool_dp[c], pool_sp[c], flags, $urandom,
                         rand_len());
        return h;
    endfunction

    // transfers are taken at the rising edge: predict inputs, check results
    always @(posedge clk)
    begin
        tfst_pkg::res_t exp_r;
        tfst_pkg::res_t got_r;
        if (rst_n)
        begin
            if (push && !full)
            begin
                exp_r = track_packet(hdr_q[sent_cnt]);
                if (exp_r.status == tfst_pkg::LS_CREATED)
                    created_cnt++;
                if (exp_r.status == tfst_pkg::LS_NONE)
                    missed_cnt++;
                flow_result_q.push_back(exp_r);
                sent_cnt++;
            end
            if (pop && !empty)
            begin
                got_r.status = lookup_status;
                got_r.index = flow_index;
                got_r.dir = direction;
                got_r.cstate = conn_state;
                got_r.dir_seq = dir_next_sequence;
                got_r.packets = dir_packet_count;
                got_r.bytes = dir_byte_count;
                got_r.seen = seen_flags;
                if (flow_result_q.size() == 0)
                begin
                    $display("%0t unexpected result: status %0d index %0d", $time,
                             lookup_status, flow_index);
                    err_cnt++;
                end
                else
                begin
                    exp_r = flow_result_q.pop_front();
                    check_field("lookup_status", 64'(exp_r.status), 64'(got_r.status));
                    check_field("flow_index", 64'(exp_r.index), 64'(got_r.index));
                    check_field("direction", 64'(exp_r.dir), 64'(got_r.dir));
                    check_field("conn_state", 64'(exp_r.cstate), 64'(got_r.cstate));
                    check_field("dir_next_sequence", 64'(exp_r.dir_seq), 64'(got_r.dir_seq));
                    check_field("dir_packet_count", 64'(exp_r.packets), 64'(got_r.packets));
                    check_field("dir_byte_count", 64'(exp_r.bytes), 64'(got_r.bytes));
                    check_field("seen_flags", 64'(exp_r.seen), 64'(got_r.seen));
                end
                got_cnt++;
            end
            // watchdog: cycles with no transfer on either side
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t timeout: no transfer for %0d cycles", $time, idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // sender: holds a shown header until its transfer, otherwise may idle
    always @(negedge clk)
    begin
        hdr_t h;
        if (rst_n)
        begin
            if (push && shown_idx == sent_cnt)
            begin
                push <= 1'b1;
            end
            else if (sent_cnt < hdr_q.size() && $urandom_range(0, 99) >= send_idle_pct)
            begin
                h = hdr_q[sent_cnt];
                shown_idx <= sent_cnt;
                source_address <= h.sa;
                dest_address <= h.da;
                source_port <= h.sp;
                dest_port <= h.dp;
                sequence_number <= h.seq;
                flag_syn <= h.syn;
                flag_ack <= h.ack;
                flag_fin <= h.fin;
                flag_rst <= h.rst;
                packet_length <= h.len;
                push <= 1'b1;
            end
            else
            begin
                push <= 1'b0;
            end
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic wait_drained();
        while (sent_cnt < hdr_q.size() || flow_result_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int n;
        int ph;
        for (n = 0; n < POOL_SIZE; n++)
            refresh_conn(n);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, no idling
        // ack with no flow is ignored
        hdr_q.push_back(make_hdr(32'h0A000001, 32'h0A000002, 16'd1000, 16'd80, 4'b0100,
                                 32'd5, 16'd60));
        // extreme tuple, sequence wraps on syn, longest packet
        hdr_q.push_back(make_hdr(32'h0, 32'hFFFFFFFF, 16'h0, 16'hFFFF, 4'b1000,
                                 32'hFFFFFFFF, 16'hFFFF));
        // syn-ack from the far side goes straight to established
        hdr_q.push_back(make_hdr(32'hFFFFFFFF, 32'h0, 16'hFFFF, 16'h0, 4'b1100, 32'h0,
                                 16'h0));
        hdr_q.push_back(make_hdr(32'h0, 32'hFFFFFFFF, 16'h0, 16'hFFFF, 4'b0100, 32'h1,
                                 16'd1));
        // fin while established moves to fin wait
        hdr_q.push_back(make_hdr(32'h0, 32'hFFFFFFFF, 16'h0, 16'hFFFF, 4'b0110, 32'h2,
                                 16'd40));
        hdr_q.push_back(make_hdr(32'hFFFFFFFF, 32'h0, 16'hFFFF, 16'h0, 4'b0110, 32'h7,
                                 16'd40));
        // reset closes it
        hdr_q.push_back(make_hdr(32'hFFFFFFFF, 32'h0, 16'hFFFF, 16'h0, 4'b0001, 32'h9,
                                 16'd40));
        // syn again on the closed flow reopens as syn sent
        hdr_q.push_back(make_hdr(32'h0, 32'hFFFFFFFF, 16'h0, 16'hFFFF, 4'b1000, 32'h100,
                                 16'd60));
        // all flags at once on a new flow
        hdr_q.push_back(make_hdr(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 4'b1111,
                                 32'hAAAA5555, 16'hFFFF));
        // tuple that is its own reverse
        hdr_q.push_back(make_hdr(32'h12345678, 32'h12345678, 16'd80, 16'd80, 4'b1000,
                                 32'h10, 16'd64));
        hdr_q.push_back(make_hdr(32'h12345678, 32'h12345678, 16'd80, 16'd80, 4'b1100,
                                 32'h20, 16'd64));
        // same addresses, ports swapped only: reverse lookup, reverse direction
        hdr_q.push_back(make_hdr(32'hC0A80001, 32'hC0A80001, 16'd1234, 16'd443, 4'b1000,
                                 32'h30, 16'd60));
        hdr_q.push_back(make_hdr(32'hC0A80001, 32'hC0A80001, 16'd443, 16'd1234, 4'b1000,
                                 32'h40, 16'd60));
        // plain ack keeps syn sent, then reverse syn-ack moves to established
        hdr_q.push_back(make_hdr(32'hC0A80001, 32'hC0A80001, 16'd443, 16'd1234, 4'b0100,
                                 32'h41, 16'd0));
        hdr_q.push_back(make_hdr(32'hC0A80001, 32'hC0A80001, 16'd443, 16'd1234, 4'b1100,
                                 32'h50, 16'd60));
        // rst with fin, and a header with no flags, on no flow are ignored
        hdr_q.push_back(make_hdr(32'h55555555, 32'hAAAAAAAA, 16'h5555, 16'hAAAA, 4'b0011,
                                 32'h0, 16'hFFFF));
        hdr_q.push_back(make_hdr(32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 16'h5555, 4'b0000,
                                 32'hFFFFFFFF, 16'h0));
        wait_drained();
        // sender holds off until every result is back
        repeat (30) @(posedge clk);

        // random traffic across idling phases
        for (ph = 0; ph < 5; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 83; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 83; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            for (n = 0; n < 260; n++)
                hdr_q.push_back(rand_hdr());
            wait_drained();
        end

        repeat (40) @(posedge clk);
        $display("sent %0d headers, %0d results checked, %0d flows created, %0d ignored",
                 sent_cnt, got_cnt, created_cnt, missed_cnt);
        $display("handshakes, fin/rst paths and idle/stall phases exercised, %0d errors",
                 err_cnt);
        if (err_cnt == 0 && flow_result_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
